FILE: design/tlvp_pkg.sv
package tlvp_pkg;

    localparam int MAX_MESSAGE_BYTES = 256;
    localparam int POS_W = (MAX_MESSAGE_BYTES > 2) ? $clog2(MAX_MESSAGE_BYTES) : 1;

    typedef enum logic [1:0] {
        PHASE_KEY,
        PHASE_HEADER,
        PHASE_VALUE
    } phase_t;

    typedef enum logic {
        KIND_RECORD    = 1'b0,
        KIND_TRUNCATED = 1'b1
    } kind_t;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       key;
        logic [1:0]       vtype;
        logic [5:0]       len;
        logic [5:0]       seen;
        logic [31:0]      acc;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] start;
        logic             pending;
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  key;
        logic [1:0]  vtype;
        logic [5:0]  len;
        logic [7:0]  offset;
        logic [31:0] num;
    } result_t;

endpackage

FILE: design/tlv_record_parser_unit.sv
// Path: a byte goes through the input register, the combinational parse step
// and the result register. Throughput: one message byte per cycle while a full
// result register is not held by a low m_ready.
// Reset: aresetn is synchronous and active low; it empties both registers and
// returns the parser to the start of a message with position zero.
module tlv_record_parser_unit
    import tlvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_record_key,
    output logic [1:0]  m_value_type,
    output logic [5:0]  m_value_len,
    output logic [7:0]  m_value_offset,
    output logic [31:0] m_numeric_value
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_eom_reg;
    logic         out_valid_reg;
    result_t      out_res_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         res_valid;
    result_t      res;
    logic         advance;

    // An item leaves the input register once the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tlvp_step u_step (
        .state_cur      (state_reg),
        .data_byte      (in_byte_reg),
        .end_of_message (in_eom_reg),
        .state_next     (state_next),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eom_reg  <= s_end_of_message;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PHASE_KEY, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_res_reg.kind;
    assign m_record_key    = out_res_reg.key;
    assign m_value_type    = out_res_reg.vtype;
    assign m_value_len     = out_res_reg.len;
    assign m_value_offset  = out_res_reg.offset;
    assign m_numeric_value = out_res_reg.num;

endmodule

FILE: design/tlvp_step.sv
module tlvp_step
    import tlvp_pkg::*;
(
    input  parse_state_t state_cur,
    input  logic [7:0]   data_byte,
    input  logic         end_of_message,
    output parse_state_t state_next,
    output logic         res_valid,
    output result_t      res
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_MESSAGE_BYTES - 1);

    logic [POS_W-1:0] pos_inc;
    logic [5:0]       seen_inc;
    logic             take_byte;

    assign pos_inc   = (state_cur.pos == LAST_POS) ? '0 : state_cur.pos + 1'b1;
    assign seen_inc  = state_cur.seen + 6'd1;
    assign take_byte = (state_cur.seen < 6'd3) ||
                       ((state_cur.seen == 6'd3) && (state_cur.len == 6'd4));

    always_comb begin
        state_next = state_cur;
        res_valid  = 1'b0;
        res        = '{kind: KIND_RECORD, key: state_cur.key, vtype: state_cur.vtype,
                       len: state_cur.len, offset: 8'(state_cur.start), num: 32'd0};
        case (state_cur.phase)
            PHASE_HEADER: begin
                state_next.vtype = data_byte[7:6];
                state_next.len   = data_byte[5:0];
                state_next.seen  = '0;
                state_next.acc   = '0;
                state_next.start = pos_inc;
                if (data_byte[5:0] == 6'd0) begin
                    state_next.pending = !end_of_message;
                    state_next.phase   = PHASE_KEY;
                end else if (end_of_message) begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_TRUNCATED;
                    res.vtype  = data_byte[7:6];
                    res.len    = data_byte[5:0];
                    res.offset = 8'(pos_inc);
                end else begin
                    state_next.phase = PHASE_VALUE;
                end
            end
            PHASE_VALUE: begin
                if (take_byte) begin
                    state_next.acc = {state_cur.acc[23:0], data_byte};
                end
                state_next.seen = seen_inc;
                if (seen_inc == state_cur.len) begin
                    res_valid        = 1'b1;
                    res.num          = state_next.acc;
                    state_next.phase = PHASE_KEY;
                end else if (end_of_message) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_TRUNCATED;
                end
            end
            default: begin
                if (state_cur.pending) begin
                    res_valid          = 1'b1;
                    res.offset         = 8'(state_cur.pos);
                    state_next.pending = 1'b0;
                end
                state_next.key   = data_byte;
                state_next.phase = PHASE_HEADER;
            end
        endcase

        if (end_of_message) begin
            state_next.phase   = PHASE_KEY;
            state_next.seen    = '0;
            state_next.acc     = '0;
            state_next.pos     = '0;
            state_next.pending = 1'b0;
        end else begin
            state_next.pos = pos_inc;
        end
    end

endmodule

FILE: tb/sv/tlv_record_parser_unit_test.sv
module tlv_record_parser_unit_test
    import tlvp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 900;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [7:0]  m_record_key;
    logic [1:0]  m_value_type;
    logic [5:0]  m_value_len;
    logic [7:0]  m_value_offset;
    logic [31:0] m_numeric_value;

    tlv_record_parser_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_message(s_end_of_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_record_key    (m_record_key),
        .m_value_type    (m_value_type),
        .m_value_len     (m_value_len),
        .m_value_offset  (m_value_offset),
        .m_numeric_value (m_numeric_value)
    );

    always #6 aclk = ~aclk;

    typedef struct {
        logic [7:0] data;
        bit         last;
        bit         typed;
        bit         has_res;
        result_t    res;
    } dir_row_t;

    dir_row_t dir_rows[25] = '{
        '{8'hAB, 1'b0, 1'b0, 1'b0, '0},
        '{8'h44, 1'b0, 1'b0, 1'b0, '0},
        '{8'h11, 1'b0, 1'b0, 1'b0, '0},
        '{8'h22, 1'b0, 1'b0, 1'b0, '0},
        '{8'h33, 1'b0, 1'b0, 1'b0, '0},
        '{8'h44, 1'b0, 1'b1, 1'b1,
          '{KIND_RECORD, 8'hAB, 2'd1, 6'd4, 8'd2, 32'h11223344}},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, 1'b1,
          '{KIND_RECORD, 8'h00, 2'd0, 6'd0, 8'd8, 32'h0}},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, 1'b1,
          '{KIND_TRUNCATED, 8'hFF, 2'd3, 6'd63, 8'd10, 32'h0}},
        '{8'h5A, 1'b0, 1'b0, 1'b0, '0},
        '{8'h85, 1'b1, 1'b1, 1'b1,
          '{KIND_TRUNCATED, 8'h5A, 2'd2, 6'd5, 8'd2, 32'h0}},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{8'h77, 1'b1, 1'b1, 1'b0, '0},
        '{8'h10, 1'b0, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, 1'b1,
          '{KIND_RECORD, 8'h10, 2'd0, 6'd3, 8'd2, 32'h00FFFFFF}},
        '{8'h20, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'h30, 1'b1, 1'b0, 1'b0, '0}
    };

    result_t expected_records[$];
    int      failures = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    bit      src_burst = 1'b0;
    bit      sink_burst = 1'b0;

    phase_t           rec_phase = PHASE_KEY;
    logic [7:0]       rec_key = '0;
    logic [1:0]       rec_type = '0;
    logic [5:0]       rec_len = '0;
    logic [5:0]       rec_seen = '0;
    logic [31:0]      rec_acc = '0;
    logic [POS_W-1:0] msg_pos = '0;
    bit               zero_pending = 1'b0;

    function automatic void parse_byte(input logic [7:0] b, input bit last,
                                       output bit made, output result_t r);
        logic [POS_W-1:0] start;
        made = 1'b0;
        r = '0;
        case (rec_phase)
            PHASE_HEADER: begin
                rec_type = b[7:6];
                rec_len = b[5:0];
                rec_seen = '0;
                rec_acc = '0;
                if (rec_len == 6'd0) begin
                    zero_pending = !last;
                    rec_phase = PHASE_KEY;
                end else if (last) begin
                    made = 1'b1;
                    r = '{KIND_TRUNCATED, rec_key, rec_type, rec_len,
                          8'(msg_pos + 1'b1), 32'h0};
                end else begin
                    rec_phase = PHASE_VALUE;
                end
            end
            PHASE_VALUE: begin
                start = msg_pos - POS_W'(rec_seen);
                if (rec_seen < 6'd3 || (rec_seen == 6'd3 && rec_len == 6'd4)) begin
                    rec_acc = {rec_acc[23:0], b};
                end
                rec_seen = rec_seen + 6'd1;
                if (rec_seen == rec_len) begin
                    made = 1'b1;
                    r = '{KIND_RECORD, rec_key, rec_type, rec_len, 8'(start), rec_acc};
                    rec_phase = PHASE_KEY;
                end else if (last) begin
                    made = 1'b1;
                    r = '{KIND_TRUNCATED, rec_key, rec_type, rec_len, 8'(start), 32'h0};
                end
            end
            default: begin
                if (zero_pending) begin
                    made = 1'b1;
                    r = '{KIND_RECORD, rec_key, rec_type, rec_len, 8'(msg_pos), 32'h0};
                    zero_pending = 1'b0;
                end
                rec_key = b;
                rec_phase = PHASE_HEADER;
            end
        endcase
        if (last) begin
            rec_phase = PHASE_KEY;
            rec_seen = '0;
            rec_acc = '0;
            msg_pos = '0;
            zero_pending = 1'b0;
        end else begin
            msg_pos = msg_pos + 1'b1;
        end
    endfunction

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input bit typed_has, input result_t typed_res);
        int      gap;
        bit      made;
        result_t r;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_end_of_message <= last;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, last, made, r);
        if (typed) begin
            made = typed_has;
            r = typed_res;
        end
        if (made) begin
            expected_records.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    initial begin
        int      gap;
        result_t want;
        @(posedge aclk);
        forever begin
            gap = draw_gap(sink_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none actual key %0h",
                         $time, m_record_key);
                failures++;
            end else begin
                want = expected_records.pop_front();
                compare_field("result_kind", 32'(want.kind), 32'(m_result_kind));
                compare_field("record_key", 32'(want.key), 32'(m_record_key));
                compare_field("value_type", 32'(want.vtype), 32'(m_value_type));
                compare_field("value_len", 32'(want.len), 32'(m_value_len));
                compare_field("value_offset", 32'(want.offset), 32'(m_value_offset));
                compare_field("numeric_value", want.num, m_numeric_value);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [7:0] msg_bytes[$];
        int         nrec;
        int         len;
        int         cut;
        int         pick;
        bit         long_done;
        long_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].has_res, dir_rows[i].res);
        end

        while (bytes_sent < RANDOM_BYTES) begin
            msg_bytes.delete();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                len = $urandom_range(1, 12);
                repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                if (pick == 1 && !long_done && bytes_sent > 300) begin
                    long_done = 1'b1;
                    nrec = 5;
                end else begin
                    nrec = $urandom_range(1, 4);
                end
                repeat (nrec) begin
                    if (nrec == 5 && long_done) begin
                        len = 63;
                    end else if ($urandom_range(0, 7) == 0) begin
                        len = $urandom_range(0, 63);
                    end else begin
                        len = $urandom_range(0, 5);
                    end
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
                    msg_bytes.push_back(8'(($urandom_range(0, 3) << 6) | len));
                    repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 4) == 0) begin
                    cut = $urandom_range(1, msg_bytes.size());
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                end
            end
            foreach (msg_bytes[i]) begin
                send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (expected_records.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
